// ----- rtl/bpc_pkg.sv -----
`default_nettype none

package bpc_pkg;

   localparam int STAGES = 10;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_COUNT       = 6;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESSURE_SENSITIVITY   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESSURE_OFFSET        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SENSITIVITY_TEMP_COEFF = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_TEMP_COEFF      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REFERENCE_TEMPERATURE  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEMPERATURE_SLOPE      = 3'd5;

   localparam int RAW_WIDTH   = 24;
   localparam int TEMP_WIDTH  = 20;
   localparam int PRESS_WIDTH = 32;

   // 20.00 degC and -15.00 degC
   localparam logic signed [TEMP_WIDTH-1:0] TEMP_REF  = 20'sd2000;
   localparam logic signed [TEMP_WIDTH-1:0] TEMP_COLD = -20'sd1500;

   typedef logic [CSR_DATA_WIDTH-1:0] coeff_type;

endpackage

`default_nettype wire

// ----- rtl/barometric_pressure_compensation.sv -----
// Barometric pressure compensation with second-order low-temperature correction.
// Input channel req_*: one transfer carries a raw 24-bit pressure and temperature
// conversion pair. Result channel rsp_*: one transfer per input carries the
// compensated temperature (0.01 degC, signed 20 bits) and pressure (0.01 mbar,
// signed 32 bits), in input order.
// Calibration coefficients C1..C6 are written through csr_we/csr_index/csr_wdata,
// indexes 0 to 5; other indexes are ignored. The user must write them only while
// no item is in flight; the block does not enforce this. The result passes
// through ten register stages (offset, first-order products, scaling, squares,
// correction terms, correction, two partial products of the pressure multiply,
// their sum, offset removal, final scaling). Throughput: one item per cycle while
// rsp_stall is low. A stall on rsp_stall holds the result register; stages behind it
// keep filling bubbles, and req_stall rises only once every stage holds an item.
// Reset (synchronous, active high) empties the pipeline and clears all
// coefficients to zero.
`default_nettype none

module barometric_pressure_compensation (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [bpc_pkg::RAW_WIDTH-1:0]         req_raw_pressure,
   input  wire  [bpc_pkg::RAW_WIDTH-1:0]         req_raw_temperature,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [bpc_pkg::TEMP_WIDTH-1:0]  rsp_temperature_centideg,
   output logic signed [bpc_pkg::PRESS_WIDTH-1:0] rsp_pressure_pascal,
   input  wire                                   csr_we,
   input  wire  [bpc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [bpc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import bpc_pkg::*;

   // coefficients
   coeff_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   // stage control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] adv;

   // stage 0
   logic [23:0]        s0_d1_ff, s0_d1_in;
   logic signed [24:0] s0_dt_ff, s0_dt_in;
   // stage 1
   logic [23:0]        s1_d1_ff;
   logic signed [41:0] s1_pt_ff, s1_pt_in;
   logic signed [41:0] s1_poff_ff, s1_poff_in;
   logic signed [41:0] s1_psens_ff, s1_psens_in;
   logic signed [49:0] s1_pdd_ff, s1_pdd_in;
   // stage 2
   logic [23:0]        s2_d1_ff;
   logic signed [19:0] s2_temp_ff, s2_temp_in;
   logic signed [39:0] s2_off_ff, s2_off_in;
   logic signed [39:0] s2_sens_ff, s2_sens_in;
   logic [16:0]        s2_t2_ff, s2_t2_in;
   // stage 3
   logic [23:0]        s3_d1_ff;
   logic signed [19:0] s3_temp_ff;
   logic signed [39:0] s3_off_ff, s3_sens_ff;
   logic [16:0]        s3_t2_ff;
   logic [34:0]        s3_lo_ff, s3_lo_in;
   logic [34:0]        s3_vlo_ff, s3_vlo_in;
   logic               s3_low_ff, s3_low_in;
   logic               s3_cold_ff, s3_cold_in;
   logic signed [19:0] s3_da, s3_db;
   logic signed [39:0] s3_sqa, s3_sqb;
   // stage 4
   logic [23:0]        s4_d1_ff;
   logic signed [19:0] s4_temp_ff;
   logic signed [39:0] s4_off_ff, s4_sens_ff;
   logic [16:0]        s4_t2_ff, s4_t2_in;
   logic [38:0]        s4_off2_ff, s4_off2_in;
   logic [38:0]        s4_sens2_ff, s4_sens2_in;
   logic [36:0]        s4_lo5;
   logic [37:0]        s4_v7;
   logic [38:0]        s4_v11;
   // stage 5
   logic [23:0]        s5_d1_ff;
   logic signed [19:0] s5_temp_ff, s5_temp_in;
   logic signed [39:0] s5_off_ff, s5_off_in;
   logic signed [39:0] s5_sens_ff, s5_sens_in;
   // stage 6
   logic signed [19:0] s6_temp_ff;
   logic signed [39:0] s6_off_ff;
   logic [43:0]        s6_pl_ff, s6_pl_in;
   logic signed [44:0] s6_ph_ff, s6_ph_in;
   // stage 7
   logic signed [19:0] s7_temp_ff;
   logic signed [39:0] s7_off_ff;
   logic [63:0]        s7_x_ff, s7_x_in;
   // stage 8
   logic signed [19:0] s8_temp_ff;
   logic signed [43:0] s8_y_ff, s8_y_in;
   // stage 9, result register
   logic signed [19:0] s9_temp_ff;
   logic signed [31:0] s9_press_ff, s9_press_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PRESSURE_SENSITIVITY:   c1_ff <= csr_wdata;
            CSR_PRESSURE_OFFSET:        c2_ff <= csr_wdata;
            CSR_SENSITIVITY_TEMP_COEFF: c3_ff <= csr_wdata;
            CSR_OFFSET_TEMP_COEFF:      c4_ff <= csr_wdata;
            CSR_REFERENCE_TEMPERATURE:  c5_ff <= csr_wdata;
            CSR_TEMPERATURE_SLOPE:      c6_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage advance, bubbles are squeezed out
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // datapath next values
   always_comb begin
      // temperature difference
      s0_d1_in = req_raw_pressure;
      s0_dt_in = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, c5_ff, 8'd0});

      // first-order products
      s1_pt_in    = s0_dt_ff * $signed({1'b0, c6_ff});
      s1_poff_in  = s0_dt_ff * $signed({1'b0, c4_ff});
      s1_psens_in = s0_dt_ff * $signed({1'b0, c3_ff});
      s1_pdd_in   = s0_dt_ff * s0_dt_ff;

      // scaling, truncating toward zero
      s2_temp_in = TEMP_REF + {s1_pt_ff[41], s1_pt_ff[41:23]}
                 + {19'd0, s1_pt_ff[41] && (|s1_pt_ff[22:0])};
      s2_off_in  = $signed({8'd0, c2_ff, 16'd0})
                 + {{5{s1_poff_ff[41]}}, s1_poff_ff[41:7]}
                 + {39'd0, s1_poff_ff[41] && (|s1_poff_ff[6:0])};
      s2_sens_in = $signed({9'd0, c1_ff, 15'd0})
                 + {{6{s1_psens_ff[41]}}, s1_psens_ff[41:8]}
                 + {39'd0, s1_psens_ff[41] && (|s1_psens_ff[7:0])};
      s2_t2_in   = s1_pdd_ff[47:31];

      // squares of the temperature deviations
      s3_da      = s2_temp_ff - TEMP_REF;
      s3_db      = s2_temp_ff - TEMP_COLD;
      s3_sqa     = s3_da * s3_da;
      s3_sqb     = s3_db * s3_db;
      s3_lo_in   = s3_sqa[34:0];
      s3_vlo_in  = s3_sqb[34:0];
      s3_low_in  = s2_temp_ff < TEMP_REF;
      s3_cold_in = s2_temp_ff < TEMP_COLD;

      // second-order terms
      s4_lo5  = {s3_lo_ff, 2'd0} + {2'd0, s3_lo_ff};
      s4_v7   = {s3_vlo_ff, 3'd0} - {3'd0, s3_vlo_ff};
      s4_v11  = {1'b0, s3_vlo_ff, 3'd0} + {3'd0, s3_vlo_ff, 1'b0} + {4'd0, s3_vlo_ff};
      s4_off2_in  = '0;
      s4_sens2_in = '0;
      s4_t2_in    = '0;
      if (s3_low_ff) begin
         s4_t2_in    = s3_t2_ff;
         s4_off2_in  = {3'd0, s4_lo5[36:1]};
         s4_sens2_in = {4'd0, s4_lo5[36:2]};
         if (s3_cold_ff) begin
            s4_off2_in  = s4_off2_in + {1'b0, s4_v7};
            s4_sens2_in = s4_sens2_in + {1'b0, s4_v11[38:1]};
         end
      end

      // apply correction
      s5_temp_in = s4_temp_ff - $signed({3'd0, s4_t2_ff});
      s5_off_in  = s4_off_ff - $signed({1'b0, s4_off2_ff});
      s5_sens_in = s4_sens_ff - $signed({1'b0, s4_sens2_ff});

      // pressure multiply as two partial products
      s6_pl_in = s5_d1_ff * s5_sens_ff[19:0];
      s6_ph_in = $signed({1'b0, s5_d1_ff}) * $signed(s5_sens_ff[39:20]);

      s7_x_in = {s6_ph_ff[43:0], 20'd0} + {20'd0, s6_pl_ff};

      s8_y_in = $signed({s7_x_ff[63], s7_x_ff[63:21]})
              - {{4{s7_off_ff[39]}}, s7_off_ff}
              + {43'd0, s7_x_ff[63] && (|s7_x_ff[20:0])};

      // result stays well inside 32 bits, so saturation never acts
      s9_press_in = {{3{s8_y_ff[43]}}, s8_y_ff[43:15]}
                  + {31'd0, s8_y_ff[43] && (|s8_y_ff[14:0])};
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_d1_ff <= s0_d1_in;
         s0_dt_ff <= s0_dt_in;
      end
      if (adv[1]) begin
         s1_d1_ff    <= s0_d1_ff;
         s1_pt_ff    <= s1_pt_in;
         s1_poff_ff  <= s1_poff_in;
         s1_psens_ff <= s1_psens_in;
         s1_pdd_ff   <= s1_pdd_in;
      end
      if (adv[2]) begin
         s2_d1_ff   <= s1_d1_ff;
         s2_temp_ff <= s2_temp_in;
         s2_off_ff  <= s2_off_in;
         s2_sens_ff <= s2_sens_in;
         s2_t2_ff   <= s2_t2_in;
      end
      if (adv[3]) begin
         s3_d1_ff   <= s2_d1_ff;
         s3_temp_ff <= s2_temp_ff;
         s3_off_ff  <= s2_off_ff;
         s3_sens_ff <= s2_sens_ff;
         s3_t2_ff   <= s2_t2_ff;
         s3_lo_ff   <= s3_lo_in;
         s3_vlo_ff  <= s3_vlo_in;
         s3_low_ff  <= s3_low_in;
         s3_cold_ff <= s3_cold_in;
      end
      if (adv[4]) begin
         s4_d1_ff    <= s3_d1_ff;
         s4_temp_ff  <= s3_temp_ff;
         s4_off_ff   <= s3_off_ff;
         s4_sens_ff  <= s3_sens_ff;
         s4_t2_ff    <= s4_t2_in;
         s4_off2_ff  <= s4_off2_in;
         s4_sens2_ff <= s4_sens2_in;
      end
      if (adv[5]) begin
         s5_d1_ff   <= s4_d1_ff;
         s5_temp_ff <= s5_temp_in;
         s5_off_ff  <= s5_off_in;
         s5_sens_ff <= s5_sens_in;
      end
      if (adv[6]) begin
         s6_temp_ff <= s5_temp_ff;
         s6_off_ff  <= s5_off_ff;
         s6_pl_ff   <= s6_pl_in;
         s6_ph_ff   <= s6_ph_in;
      end
      if (adv[7]) begin
         s7_temp_ff <= s6_temp_ff;
         s7_off_ff  <= s6_off_ff;
         s7_x_ff    <= s7_x_in;
      end
      if (adv[8]) begin
         s8_temp_ff <= s7_temp_ff;
         s8_y_ff    <= s8_y_in;
      end
      if (adv[9]) begin
         s9_temp_ff  <= s8_temp_ff;
         s9_press_ff <= s9_press_in;
      end
   end

   assign rsp_valid                = valid_ff[STAGES-1];
   assign rsp_temperature_centideg = s9_temp_ff;
   assign rsp_pressure_pascal      = s9_press_ff;

`ifndef SYNTH
   // input is held off only when every stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
   else $error("input stalled with a free stage");

   // items in flight change only through transfers
   assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && !req_stall) && !(rsp_valid && !rsp_stall))
      |=> ($countones(valid_ff) == $past($countones(valid_ff))))
   else $error("item lost or invented in pipeline");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
   else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- verif/compensation_checker.sv -----
module compensation_checker (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   input  wire                                    req_stall,
   input  wire        [bpc_pkg::RAW_WIDTH-1:0]    req_raw_pressure,
   input  wire        [bpc_pkg::RAW_WIDTH-1:0]    req_raw_temperature,
   input  wire                                    rsp_valid,
   input  wire                                    rsp_stall,
   input  wire signed [bpc_pkg::TEMP_WIDTH-1:0]   rsp_temperature_centideg,
   input  wire signed [bpc_pkg::PRESS_WIDTH-1:0]  rsp_pressure_pascal,
   input  wire                                    csr_we,
   input  wire [bpc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire [bpc_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   output int                                     failures,
   output int                                     pending_readings,
   output int                                     readings_checked,
   output int                                     cool_readings,
   output int                                     cold_readings
);
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam longint WARM_LIMIT = 2000;
   localparam longint COLD_LIMIT = -1500;
   localparam longint PRESS_MAX  = 64'sd2147483647;
   localparam longint PRESS_MIN  = -64'sd2147483648;

   typedef struct packed {
      logic signed [TEMP_WIDTH-1:0]  temperature;
      logic signed [PRESS_WIDTH-1:0] pressure;
      logic                          second_order;
      logic                          extra_cold;
   } reading_type;

   coeff_type   coeffs [CSR_COUNT];
   reading_type expected_readings [$];

   function automatic reading_type compensate(logic [RAW_WIDTH-1:0] raw_p,
                                              logic [RAW_WIDTH-1:0] raw_t);
      longint      d1, d2, dt, temp, off, sens, press, t2, dev, cold, off2, sens2;
      reading_type r;
      d1   = longint'(raw_p);
      d2   = longint'(raw_t);
      dt   = d2 - longint'(coeffs[CSR_REFERENCE_TEMPERATURE]) * 256;
      temp = WARM_LIMIT + dt * longint'(coeffs[CSR_TEMPERATURE_SLOPE]) / 8388608;
      off  = longint'(coeffs[CSR_PRESSURE_OFFSET]) * 65536
           + longint'(coeffs[CSR_OFFSET_TEMP_COEFF]) * dt / 128;
      sens = longint'(coeffs[CSR_PRESSURE_SENSITIVITY]) * 32768
           + longint'(coeffs[CSR_SENSITIVITY_TEMP_COEFF]) * dt / 256;
      r.second_order = (temp < WARM_LIMIT);
      r.extra_cold   = (temp < COLD_LIMIT);
      if (temp < WARM_LIMIT) begin
         t2    = dt * dt / 64'sd2147483648;
         dev   = (temp - WARM_LIMIT) * (temp - WARM_LIMIT);
         off2  = 5 * dev / 2;
         sens2 = 5 * dev / 4;
         // squares use the first-order temperature
         if (temp < COLD_LIMIT) begin
            cold  = (temp - COLD_LIMIT) * (temp - COLD_LIMIT);
            off2  = off2 + 7 * cold;
            sens2 = sens2 + 11 * cold / 2;
         end
         temp = temp - t2;
         off  = off - off2;
         sens = sens - sens2;
      end
      press = (d1 * sens / 2097152 - off) / 32768;
      if (press > PRESS_MAX) begin
         press = PRESS_MAX;
      end else if (press < PRESS_MIN) begin
         press = PRESS_MIN;
      end
      r.temperature = temp[TEMP_WIDTH-1:0];
      r.pressure    = press[PRESS_WIDTH-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         foreach (coeffs[i]) coeffs[i] = '0;
         expected_readings.delete();
      end else begin
         if (csr_we && csr_index < CSR_COUNT) coeffs[csr_index] = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result transfer, temperature %0d pressure %0d",
                        $time, rsp_temperature_centideg, rsp_pressure_pascal);
               failures++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature_centideg !== want.temperature) begin
                  $display("%0t: temperature expected %0d actual %0d", $time,
                           want.temperature, rsp_temperature_centideg);
                  failures++;
               end
               if (rsp_pressure_pascal !== want.pressure) begin
                  $display("%0t: pressure expected %0d actual %0d", $time,
                           want.pressure, rsp_pressure_pascal);
                  failures++;
               end
               readings_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            want = compensate(req_raw_pressure, req_raw_temperature);
            if (want.second_order) cool_readings++;
            if (want.extra_cold) cold_readings++;
            expected_readings.push_back(want);
         end
      end
      pending_readings <= expected_readings.size();
   end

endmodule

// ----- verif/barometric_pressure_compensation_tb.sv -----
module barometric_pressure_compensation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 2 * STAGES + 4;
   localparam int HOLD_OFF_CYCLES = 80;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW  = CSR_INDEX_WIDTH'(CSR_COUNT);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HIGH = '1;

   typedef enum {COEFF_TYPICAL, COEFF_MAX, COEFF_ZERO, COEFF_RANDOM} coeff_kind_type;

   logic                          clock               = 1'b0;
   logic                          reset               = 1'b1;
   logic                          req_valid           = 1'b0;
   logic [RAW_WIDTH-1:0]          req_raw_pressure    = '0;
   logic [RAW_WIDTH-1:0]          req_raw_temperature = '0;
   logic                          rsp_stall           = 1'b0;
   logic                          csr_we              = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index           = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata           = '0;
   wire                           req_stall;
   wire                           rsp_valid;
   wire signed [TEMP_WIDTH-1:0]   rsp_temperature_centideg;
   wire signed [PRESS_WIDTH-1:0]  rsp_pressure_pascal;

   int        failures;
   int        pending_readings;
   int        readings_checked;
   int        cool_readings;
   int        cold_readings;
   int        sender_idle_pct    = 0;
   int        receiver_stall_pct = 0;
   int        hold_off_left      = 0;
   int        hold_off_requests  = 0;
   int        hold_off_served    = 0;
   int        cycle_count        = 0;
   int        coeff_sets_loaded  = 0;
   coeff_type coeff_set [CSR_COUNT];

   barometric_pressure_compensation dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_raw_pressure         (req_raw_pressure),
      .req_raw_temperature      (req_raw_temperature),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_temperature_centideg (rsp_temperature_centideg),
      .rsp_pressure_pascal      (rsp_pressure_pascal),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   compensation_checker reading_check (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_raw_pressure         (req_raw_pressure),
      .req_raw_temperature      (req_raw_temperature),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_temperature_centideg (rsp_temperature_centideg),
      .rsp_pressure_pascal      (rsp_pressure_pascal),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .failures                 (failures),
      .pending_readings         (pending_readings),
      .readings_checked         (readings_checked),
      .cool_readings            (cool_readings),
      .cold_readings            (cold_readings)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: long hold-off when requested, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         rsp_stall       <= 1'b1;
         hold_off_left   <= HOLD_OFF_CYCLES - 1;
         hold_off_served <= hold_off_requests;
      end else if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic send_sample(input logic [RAW_WIDTH-1:0] raw_p,
                              input logic [RAW_WIDTH-1:0] raw_t);
      req_valid           <= 1'b1;
      req_raw_pressure    <= raw_p;
      req_raw_temperature <= raw_t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid           <= 1'b0;
         req_raw_pressure    <= RAW_WIDTH'($urandom);
         req_raw_temperature <= RAW_WIDTH'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_random_sample();
      logic [RAW_WIDTH-1:0] raw_p;
      logic [RAW_WIDTH-1:0] raw_t;
      int                   near;
      raw_p = RAW_WIDTH'($urandom);
      case ($urandom_range(3))
         0, 1: raw_t = RAW_WIDTH'($urandom);
         2: begin
            // around the reference point, across both correction thresholds
            near = int'(coeff_set[CSR_REFERENCE_TEMPERATURE]) * 256
                 + int'($urandom_range(8388608)) - 4194304;
            if (near < 0) near = 0;
            if (near > 16777215) near = 16777215;
            raw_t = RAW_WIDTH'(near);
         end
         default: begin
            raw_p = $urandom_range(1) ? '1 : RAW_WIDTH'($urandom_range(255));
            raw_t = $urandom_range(1) ? '1 : RAW_WIDTH'($urandom_range(255));
         end
      endcase
      send_sample(raw_p, raw_t);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_readings != 0);
   endtask

   task automatic load_coeffs(input coeff_kind_type kind);
      foreach (coeff_set[i]) begin
         case (kind)
            COEFF_MAX:    coeff_set[i] = '1;
            COEFF_ZERO:   coeff_set[i] = '0;
            COEFF_RANDOM: coeff_set[i] = CSR_DATA_WIDTH'($urandom);
            default:      coeff_set[i] = '0;
         endcase
      end
      if (kind == COEFF_TYPICAL) begin
         coeff_set[CSR_PRESSURE_SENSITIVITY]   = 16'd40127;
         coeff_set[CSR_PRESSURE_OFFSET]        = 16'd36924;
         coeff_set[CSR_SENSITIVITY_TEMP_COEFF] = 16'd23317;
         coeff_set[CSR_OFFSET_TEMP_COEFF]      = 16'd23282;
         coeff_set[CSR_REFERENCE_TEMPERATURE]  = 16'd33464;
         coeff_set[CSR_TEMPERATURE_SLOPE]      = 16'd28312;
      end
      for (int i = 0; i < CSR_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(i);
         csr_wdata <= coeff_set[i];
         @(posedge clock);
      end
      // writes to unmapped indexes must leave the coefficients alone
      csr_index <= CSR_UNUSED_LOW;
      csr_wdata <= CSR_DATA_WIDTH'($urandom);
      @(posedge clock);
      csr_index <= CSR_UNUSED_HIGH;
      csr_wdata <= CSR_DATA_WIDTH'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      coeff_sets_loaded++;
   endtask

   task automatic run_phase(input coeff_kind_type kind, input int count,
                            input int idle_pct, input int stall_pct);
      load_coeffs(kind);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_random_sample();
      wait_until_drained();
   endtask

   initial begin
      int ref_raw;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coefficients still at their reset value
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample('1, '0);
      wait_until_drained();

      load_coeffs(COEFF_TYPICAL);
      ref_raw = int'(coeff_set[CSR_REFERENCE_TEMPERATURE]) * 256;
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample('0, '1);
      send_sample('1, '0);
      send_sample(24'd9085466, 24'd8569150);
      // exactly at 20 degC, then truncation toward zero just below it
      send_sample(24'd9085466, RAW_WIDTH'(ref_raw));
      send_sample(24'd9085466, RAW_WIDTH'(ref_raw - 1));
      send_sample(24'd9085466, RAW_WIDTH'(ref_raw - 297));
      // -15.00 degC exactly, then one step colder
      send_sample(24'd9085466, RAW_WIDTH'(ref_raw - 1037021));
      send_sample(24'd9085466, RAW_WIDTH'(ref_raw - 1037318));
      send_sample('1, RAW_WIDTH'(ref_raw - 1037318));
      send_sample(24'h555555, 24'hAAAAAA);
      send_sample(24'hAAAAAA, 24'h555555);
      send_sample(24'h800000, 24'h7FFFFF);
      wait_until_drained();

      run_phase(COEFF_TYPICAL, 150, 0, 0);
      run_phase(COEFF_MAX, 100, 86, 0);
      run_phase(COEFF_RANDOM, 100, 0, 86);
      run_phase(COEFF_ZERO, 60, 17, 17);

      // results held back while the sender keeps offering, so the input stalls
      load_coeffs(COEFF_RANDOM);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_requests <= hold_off_requests + 1;
      repeat (40) send_random_sample();
      sender_idle_pct    = 17;
      receiver_stall_pct = 17;
      repeat (60) send_random_sample();
      wait_until_drained();

      run_phase(COEFF_RANDOM, 100, 0, 0);
      run_phase(COEFF_TYPICAL, 100, 17, 17);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d compensated readings over %0d coefficient sets",
               readings_checked, coeff_sets_loaded);
      $display("%0d below 20 degC with second-order correction, %0d of them below -15 degC",
               cool_readings, cold_readings);
      if (failures == 0 && pending_readings == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
